// ===== sv/fbb_pkg.sv =====
// Package with operation codes and shared constants of the framebuffer blitter.
`default_nettype none
package fbb_pkg;
   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_RECT   = 3'd1,
      OP_TILE   = 3'd2,
      OP_LOAD   = 3'd3,
      OP_SPRITE = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   localparam logic [15:0] KEY_COLOR = 16'hF81F;
   localparam int TILE_SIZE = 8;
   localparam logic [5:0] LAST_PIXEL = 6'd63;
endpackage
`default_nettype wire

// ===== sv/fbb_frame_mem.sv =====
// Single-port frame memory with registered read data.
`default_nettype none
module fbb_frame_mem #(
   parameter int DEPTH = 19200,
   parameter int AW = 15
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [15:0]   wr_data,
   output logic [15:0]        rd_data
);
   logic [15:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== sv/framebuffer_blitter.sv =====
// Commands walk one pixel per cycle: clear over the whole screen, a rect over its clipped
// area, a tile and a sprite over an 8x8 block; a load and a read have no walk.
// The result is then held until taken, and the next command is accepted in the cycle after.
// One pixel address/compare unit is shared by clear, rect, tile, sprite and read, set by
// the one frame memory port. After reset a clearing pass writes zero to every frame
// memory address; no command is accepted until it ends.
`default_nettype none
module framebuffer_blitter import fbb_pkg::*; #(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 120,
   parameter int SPRITE_COUNT  = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_operation,
   input  wire logic signed [9:0] req_pos_x,
   input  wire logic signed [9:0] req_pos_y,
   input  wire logic signed [9:0] req_width,
   input  wire logic signed [9:0] req_height,
   input  wire logic [15:0]       req_fill_color,
   input  wire logic [15:0]       req_top_row_color,
   input  wire logic [5:0]        req_sprite_id,
   input  wire logic [5:0]        req_pixel_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [15:0]            rsp_read_color,
   output logic                   rsp_status
);
   localparam int FDEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int FAW = $clog2(FDEPTH);
   localparam int SDEPTH = SPRITE_COUNT * 64;
   localparam int SAW = $clog2(SDEPTH);
   localparam int IDW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_WALK, ST_SPR_RD, ST_READ, ST_READ_WAIT, ST_RESP
   } state_type;

   state_type state_ff;
   logic signed [11:0] x_ff, y_ff, xs_ff, x1_ff, y1_ff;
   logic [15:0] color_ff, top_ff;
   logic [2:0]  tk_ff, tr_ff;
   logic        is_tile_ff, last_ff;
   logic [FAW-1:0] init_ff;
   logic [IDW-1:0] sid_ff;
   logic [SPRITE_COUNT-1:0] loaded_ff;
   logic [15:0] rcolor_ff;
   logic        status_ff;
   logic        pend_ff;
   logic signed [11:0] pend_x_ff, pend_y_ff;

   logic [15:0] sprite_mem [SDEPTH];
   logic [15:0] spr_data;

   // Shared address unit: one multiply-add per cycle.
   logic signed [11:0] ax, ay;
   logic        a_on;
   logic [FAW-1:0] a_addr;
   logic        f_we;
   logic [FAW-1:0] f_addr;
   logic [15:0] f_wdata, f_rdata;

   always_comb begin
      a_on = (ax >= 0) && (ax < 12'(SCREEN_WIDTH)) && (ay >= 0) && (ay < 12'(SCREEN_HEIGHT));
      a_addr = FAW'(22'(ay) * 22'(SCREEN_WIDTH) + 22'(ax));
   end

   wire logic signed [11:0] rx = 12'(req_pos_x);
   wire logic signed [11:0] ry = 12'(req_pos_y);
   wire logic id_ok = {1'b0, req_sprite_id} < 7'(SPRITE_COUNT);
   wire logic [IDW-1:0] rid = IDW'(req_sprite_id);
   wire logic signed [11:0] rx1 = rx + 12'(req_width);
   wire logic signed [11:0] ry1 = ry + 12'(req_height);

   always_comb begin
      ax = x_ff;
      ay = y_ff;
      if (state_ff == ST_IDLE) begin
         ax = rx;
         ay = ry;
      end else if (state_ff == ST_SPR_RD) begin
         ax = pend_x_ff;
         ay = pend_y_ff;
      end
      f_we = 1'b0;
      f_addr = a_addr;
      f_wdata = is_tile_ff && (tr_ff == 3'd0) ? top_ff : color_ff;
      if (state_ff == ST_INIT) begin
         f_we = 1'b1;
         f_addr = init_ff;
         f_wdata = '0;
      end else if (state_ff == ST_WALK) begin
         f_we = a_on;
      end else if (state_ff == ST_SPR_RD) begin
         f_we = pend_ff && a_on && (spr_data != KEY_COLOR);
         f_wdata = spr_data;
      end
   end

   fbb_frame_mem #(.DEPTH(FDEPTH), .AW(FAW)) u_frame (
      .clock(clock), .wr_en(f_we), .addr(f_addr), .wr_data(f_wdata), .rd_data(f_rdata)
   );

   // Sprite store: written on load, read one pixel per cycle during a blit.
   logic [SAW-1:0] s_raddr;
   assign s_raddr = SAW'({sid_ff, tr_ff, tk_ff});
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_operation == OP_LOAD && id_ok) begin
         sprite_mem[SAW'({rid, req_pixel_index})] <= req_fill_color;
      end
      spr_data <= sprite_mem[s_raddr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_read_color = rcolor_ff;
   assign rsp_status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         init_ff   <= '0;
         loaded_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == FAW'(FDEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  rcolor_ff <= '0;
                  status_ff <= 1'b0;
                  color_ff <= req_fill_color;
                  top_ff <= req_top_row_color;
                  tk_ff <= '0;
                  tr_ff <= '0;
                  is_tile_ff <= 1'b0;
                  pend_ff <= 1'b0;
                  sid_ff <= rid;
                  state_ff <= ST_RESP;
                  case (req_operation)
                     OP_CLEAR: begin
                        x_ff <= '0; y_ff <= '0; xs_ff <= '0;
                        x1_ff <= 12'(SCREEN_WIDTH); y1_ff <= 12'(SCREEN_HEIGHT);
                        state_ff <= ST_WALK;
                     end
                     OP_RECT: begin
                        if (req_width > 0 && req_height > 0) begin
                           x_ff <= (rx < 0) ? 12'sd0 : rx;
                           xs_ff <= (rx < 0) ? 12'sd0 : rx;
                           y_ff <= (ry < 0) ? 12'sd0 : ry;
                           x1_ff <= (rx1 > 12'(SCREEN_WIDTH)) ? 12'(SCREEN_WIDTH) : rx1;
                           y1_ff <= (ry1 > 12'(SCREEN_HEIGHT)) ? 12'(SCREEN_HEIGHT) : ry1;
                           if (((rx < 0) ? 12'sd0 : rx) < rx1
                               && ((rx < 0) ? 12'sd0 : rx) < 12'(SCREEN_WIDTH)
                               && ((ry < 0) ? 12'sd0 : ry) < ry1
                               && ((ry < 0) ? 12'sd0 : ry) < 12'(SCREEN_HEIGHT)) begin
                              state_ff <= ST_WALK;
                           end
                        end
                     end
                     OP_TILE: begin
                        x_ff <= rx; y_ff <= ry; xs_ff <= rx;
                        x1_ff <= rx + 12'sd8; y1_ff <= ry + 12'sd8;
                        is_tile_ff <= 1'b1;
                        state_ff <= ST_WALK;
                     end
                     OP_LOAD: begin
                        if (!id_ok) begin
                           status_ff <= 1'b1;
                        end else if (req_pixel_index == LAST_PIXEL) begin
                           loaded_ff[rid] <= 1'b1;
                        end
                     end
                     OP_SPRITE: begin
                        x_ff <= rx; y_ff <= ry; xs_ff <= rx;
                        x1_ff <= rx + 12'sd8; y1_ff <= ry + 12'sd8;
                        if (!id_ok || !loaded_ff[rid]) begin
                           status_ff <= 1'b1;
                        end else begin
                           last_ff <= 1'b0;
                           state_ff <= ST_SPR_RD;
                        end
                     end
                     OP_READ: begin
                        // Reads hold their address in x_ff/y_ff through the memory latency.
                        x_ff <= rx;
                        y_ff <= ry;
                        if (a_on) begin
                           state_ff <= ST_READ;
                        end else begin
                           status_ff <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_WALK: begin
               if (x_ff + 12'sd1 >= x1_ff) begin
                  x_ff <= xs_ff;
                  y_ff <= y_ff + 12'sd1;
                  tr_ff <= tr_ff + 3'd1;
                  if (y_ff + 12'sd1 >= y1_ff) begin
                     state_ff <= ST_RESP;
                  end
               end else begin
                  x_ff <= x_ff + 12'sd1;
               end
            end
            ST_SPR_RD: begin
               // Sprite read data is registered, so each pixel is written in the cycle
               // after its address is issued.
               pend_ff <= !last_ff;
               pend_x_ff <= x_ff + 12'(tk_ff);
               pend_y_ff <= y_ff + 12'(tr_ff);
               if (last_ff) begin
                  state_ff <= ST_RESP;
               end else begin
                  tk_ff <= tk_ff + 3'd1;
                  if (tk_ff == 3'd7) begin
                     tr_ff <= tr_ff + 3'd1;
                     if (tr_ff == 3'd7) begin
                        last_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
               rcolor_ff <= f_rdata;
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready and response valid together");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_color) && $stable(rsp_status))
      else $error("response changed while stalled");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !f_we)
      else $error("frame write while idle");
`endif
endmodule
`default_nettype wire
